### rtl/range_mode_query_sorted_assert.svh
// ----------------------------------------------------------------------------
// range_mode_query_sorted_assert
// assertion macros for the range mode query block
// ----------------------------------------------------------------------------
`ifndef RANGE_MODE_QUERY_SORTED_ASSERT_SVH
`define RANGE_MODE_QUERY_SORTED_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RMQS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RMQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rmqs_pkg.sv
// ----------------------------------------------------------------------------
// rmqs_pkg
// shared constants for the range mode query block
// ----------------------------------------------------------------------------
`default_nettype none

package rmqs_pkg;

    // array size and derived widths
    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int TREE_AW      = ADDR_W + 1;
    localparam int NODE_W       = TREE_AW + 1;
    localparam int POS_W        = 11;
    localparam int VAL_W        = 32;

    // operation codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

`default_nettype wire

### rtl/rmqs_ram.sv
// ----------------------------------------------------------------------------
// rmqs_ram
// simple dual-port ram, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rmqs_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/range_mode_query_sorted.sv
// query with built tables: reads the run tables at both range ends, takes the longer
// clipped edge run and, when whole runs lie inside the range, walks the max tree upward
// first query after a value write or count write rebuilds first: run starts upward, run
// ends and leaves downward, then inner nodes; the rebuild is set by the single read port
// of each table and the two tree copies; reset is synchronous active low, clears control
// state, sets element count to 1 and marks the tables stale
// ----------------------------------------------------------------------------
// range_mode_query_sorted
// longest clipped run of equal values over a position range, table based
// ----------------------------------------------------------------------------
`default_nettype none

module range_mode_query_sorted (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [rmqs_pkg::POS_W-1:0] i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_func,
    input  wire logic [rmqs_pkg::POS_W-1:0] i_index_or_left,
    input  wire logic [rmqs_pkg::POS_W-1:0] i_right_end,
    input  wire logic signed [rmqs_pkg::VAL_W-1:0] i_element_value,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [rmqs_pkg::POS_W-1:0]      o_mode_count,
    output logic                            o_range_error
);

    localparam int P  = rmqs_pkg::POS_W;
    localparam int AW = rmqs_pkg::ADDR_W;
    localparam int TW = rmqs_pkg::TREE_AW;
    localparam int NW = rmqs_pkg::NODE_W;
    localparam int VW = rmqs_pkg::VAL_W;
    localparam logic [P-1:0]  MAX_P  = P'(rmqs_pkg::MAX_ELEMENTS);
    localparam logic [NW-1:0] MAX_N  = NW'(rmqs_pkg::MAX_ELEMENTS);
    localparam logic [AW-1:0] TOP_ND = AW'(rmqs_pkg::MAX_ELEMENTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FWD_RD, ST_FWD_WR, ST_BWD_RD, ST_BWD_WR, ST_NODE_RD,
        ST_NODE_WR, ST_Q_RD, ST_Q_CALC, ST_T_RD, ST_T_ACC, ST_DONE
    } t_state;

    t_state         r_state, n_state;
    logic [P-1:0]   r_count, n_count;
    logic           r_tables_valid, n_tables_valid;
    logic [P-1:0]   r_i, n_i;
    logic [AW-1:0]  r_node, n_node;
    logic [VW-1:0]  r_prev_val, n_prev_val;
    logic [P-1:0]   r_prev_link, n_prev_link;
    logic [P-1:0]   r_left, n_left;
    logic [P-1:0]   r_right, n_right;
    logic [NW-1:0]  r_lo, n_lo;
    logic [NW-1:0]  r_hi, n_hi;
    logic           r_use_lo, n_use_lo;
    logic           r_use_hi, n_use_hi;
    logic [P-1:0]   r_best, n_best;
    logic           r_err, n_err;
    logic           r_out_valid, n_out_valid;
    logic [P-1:0]   r_out_count, n_out_count;
    logic           r_out_err, n_out_err;

    // memory ports
    logic           val_we, sb_we, ea_we, tree_we;
    logic [AW-1:0]  val_waddr, sb_waddr, ea_waddr;
    logic [TW-1:0]  tree_waddr;
    logic [VW-1:0]  val_wdata, val_rdata;
    logic [P-1:0]   sb_wdata, ea_wdata, tree_wdata;
    logic [AW-1:0]  val_raddr, sb_raddr, ea_raddr;
    logic [TW-1:0]  ta_raddr, tb_raddr;
    logic [P-1:0]   sb_rdata, ea_rdata, ta_rdata, tb_rdata;

    logic [P-1:0]   pos_m1, link, leaf, cand_a, cand_b, clip_r, clip_l, mx;
    logic [NW-1:0]  hi_m1;
    logic           in_accept, bad_query;

    assign pos_m1    = r_i - P'(1);
    assign hi_m1     = r_hi - NW'(1);
    assign val_raddr = pos_m1[AW-1:0];
    assign sb_raddr  = (r_state == ST_BWD_RD) ? pos_m1[AW-1:0] : AW'(r_right - P'(1));
    assign ea_raddr  = AW'(r_left - P'(1));
    assign ta_raddr  = (r_state == ST_NODE_RD) ? {r_node, 1'b0} : r_lo[TW-1:0];
    assign tb_raddr  = (r_state == ST_NODE_RD) ? {r_node, 1'b1} : hi_m1[TW-1:0];

    rmqs_ram #(.AW(AW), .DW(VW)) u_values (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_raddr(val_raddr), .o_rdata(val_rdata)
    );
    rmqs_ram #(.AW(AW), .DW(P)) u_start_before (
        .i_clk(i_clk), .i_we(sb_we), .i_waddr(sb_waddr), .i_wdata(sb_wdata),
        .i_raddr(sb_raddr), .o_rdata(sb_rdata)
    );
    rmqs_ram #(.AW(AW), .DW(P)) u_end_after (
        .i_clk(i_clk), .i_we(ea_we), .i_waddr(ea_waddr), .i_wdata(ea_wdata),
        .i_raddr(ea_raddr), .o_rdata(ea_rdata)
    );
    // two copies of the max tree give two read ports
    rmqs_ram #(.AW(TW), .DW(P)) u_tree_a (
        .i_clk(i_clk), .i_we(tree_we), .i_waddr(tree_waddr), .i_wdata(tree_wdata),
        .i_raddr(ta_raddr), .o_rdata(ta_rdata)
    );
    rmqs_ram #(.AW(TW), .DW(P)) u_tree_b (
        .i_clk(i_clk), .i_we(tree_we), .i_waddr(tree_waddr), .i_wdata(tree_wdata),
        .i_raddr(tb_raddr), .o_rdata(tb_rdata)
    );

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_mode_count  = r_out_count;
    assign o_range_error = r_out_err;
    assign in_accept     = i_valid && o_ready;
    assign bad_query     = (i_index_or_left == P'(0)) || (i_right_end > r_count)
                           || (i_index_or_left > i_right_end);

    // clipped run lengths at the two range ends
    assign clip_r = (r_right + P'(1) < ea_rdata) ? r_right + P'(1) : ea_rdata;
    assign cand_a = clip_r - r_left;
    assign clip_l = (sb_rdata > r_left - P'(1)) ? sb_rdata : r_left - P'(1);
    assign cand_b = r_right - clip_l;
    assign mx     = (ta_rdata > tb_rdata) ? ta_rdata : tb_rdata;
    assign link   = r_prev_link;
    assign leaf   = ea_wdata - sb_rdata - P'(1);

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_tables_valid = r_tables_valid;
        n_i            = r_i;
        n_node         = r_node;
        n_prev_val     = r_prev_val;
        n_prev_link    = r_prev_link;
        n_left         = r_left;
        n_right        = r_right;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_use_lo       = r_use_lo;
        n_use_hi       = r_use_hi;
        n_best         = r_best;
        n_err          = r_err;
        n_out_valid    = r_out_valid;
        n_out_count    = r_out_count;
        n_out_err      = r_out_err;
        val_we         = 1'b0;
        val_waddr      = AW'(i_index_or_left - P'(1));
        val_wdata      = i_element_value;
        sb_we          = 1'b0;
        sb_waddr       = pos_m1[AW-1:0];
        sb_wdata       = ((r_i != P'(1)) && (val_rdata == r_prev_val)) ? link : pos_m1;
        ea_we          = 1'b0;
        ea_waddr       = pos_m1[AW-1:0];
        ea_wdata       = ((r_i != r_count) && (val_rdata == r_prev_val))
                         ? link : r_i + P'(1);
        tree_we        = 1'b0;
        tree_waddr     = TW'(MAX_N + NW'(pos_m1));
        tree_wdata     = P'(0);

        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_count        = (i_cfg_data > MAX_P) ? MAX_P : i_cfg_data;
            n_tables_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_left  = i_index_or_left;
                    n_right = i_right_end;
                    if (i_func == rmqs_pkg::FUNC_WRITE) begin
                        if ((i_index_or_left != P'(0)) && (i_index_or_left <= MAX_P)) begin
                            val_we         = 1'b1;
                            n_tables_valid = 1'b0;
                        end
                    end else if (bad_query) begin
                        n_best  = P'(0);
                        n_err   = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_err = 1'b0;
                        n_i   = P'(1);
                        n_state = r_tables_valid ? ST_Q_RD : ST_FWD_RD;
                    end
                end
            end
            ST_FWD_RD: n_state = ST_FWD_WR;
            // run start before each position, walking upward
            ST_FWD_WR: begin
                sb_we       = 1'b1;
                n_prev_val  = val_rdata;
                n_prev_link = sb_wdata;
                if (r_i == r_count) begin
                    n_i     = MAX_P;
                    n_state = ST_BWD_RD;
                end else begin
                    n_i     = r_i + P'(1);
                    n_state = ST_FWD_RD;
                end
            end
            // leaves past the count are cleared on the way down
            ST_BWD_RD: begin
                if (r_i > r_count) begin
                    tree_we = 1'b1;
                    n_i     = r_i - P'(1);
                end else begin
                    n_state = ST_BWD_WR;
                end
            end
            // run end after each position and the leaf length
            ST_BWD_WR: begin
                ea_we       = 1'b1;
                tree_we     = 1'b1;
                tree_wdata  = leaf;
                n_prev_val  = val_rdata;
                n_prev_link = ea_wdata;
                if (r_i == P'(1)) begin
                    n_node  = TOP_ND;
                    n_state = ST_NODE_RD;
                end else begin
                    n_i     = r_i - P'(1);
                    n_state = ST_BWD_RD;
                end
            end
            ST_NODE_RD: n_state = ST_NODE_WR;
            // inner nodes from the bottom up
            ST_NODE_WR: begin
                tree_we    = 1'b1;
                tree_waddr = TW'(r_node);
                tree_wdata = mx;
                if (r_node == AW'(1)) begin
                    n_tables_valid = 1'b1;
                    n_state        = ST_Q_RD;
                end else begin
                    n_node  = r_node - AW'(1);
                    n_state = ST_NODE_RD;
                end
            end
            ST_Q_RD: n_state = ST_Q_CALC;
            // edge runs, then the span of whole runs in between
            ST_Q_CALC: begin
                n_best = (cand_a > cand_b) ? cand_a : cand_b;
                if ((ea_rdata <= sb_rdata) && (ea_rdata != P'(0))) begin
                    n_lo    = NW'(ea_rdata) - NW'(1) + MAX_N;
                    n_hi    = NW'(sb_rdata) + MAX_N;
                    n_state = ST_T_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_T_RD: begin
                if (r_lo < r_hi) begin
                    n_use_lo = r_lo[0];
                    n_use_hi = r_hi[0];
                    n_state  = ST_T_ACC;
                end else begin
                    n_state = ST_DONE;
                end
            end
            // fold in the selected nodes and climb one level
            ST_T_ACC: begin
                if (r_use_lo && (ta_rdata > n_best)) begin
                    n_best = ta_rdata;
                end
                if (r_use_hi && (tb_rdata > n_best)) begin
                    n_best = tb_rdata;
                end
                n_lo    = (r_lo + NW'(r_lo[0])) >> 1;
                n_hi    = (r_hi - NW'(r_hi[0])) >> 1;
                n_state = ST_T_RD;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_best;
                    n_out_err   = r_err;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= P'(1);
            r_tables_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_tables_valid <= n_tables_valid;
            r_out_valid    <= n_out_valid;
        end
        r_i         <= n_i;
        r_node      <= n_node;
        r_prev_val  <= n_prev_val;
        r_prev_link <= n_prev_link;
        r_left      <= n_left;
        r_right     <= n_right;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_use_lo    <= n_use_lo;
        r_use_hi    <= n_use_hi;
        r_best      <= n_best;
        r_err       <= n_err;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

`include "range_mode_query_sorted_assert.svh"

    // checks
    `RMQS_ASSERT_NOW(a_err_zero, r_out_valid && r_out_err, r_out_count == P'(0), "error beat with nonzero count")
    `RMQS_ASSERT_NOW(a_q_tables, r_state == ST_Q_RD, r_tables_valid, "query read with stale tables")
    `RMQS_ASSERT_NOW(a_count_max, r_out_valid, r_out_count <= MAX_P, "count above array size")
    `RMQS_ASSERT_NEXT(a_walk_step, (r_state == ST_T_RD) && (r_lo < r_hi), r_state == ST_T_ACC, "tree walk skipped a level")

endmodule

`default_nettype wire
